// ===== design/rrm_pkg.sv =====
package rrm_pkg;

  localparam int MAX_MEMBERS = 16;
  localparam int PW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;  // position width
  localparam int CW = $clog2(MAX_MEMBERS + 1);                      // count width
  localparam int DW = 32;                                           // {id, score}

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_REMOVE = 3'd1,
    FN_NEXT   = 3'd2,
    FN_SKIP   = 3'd3,
    FN_CHECK  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTIED   = 3'd4,
    ST_WINNER    = 3'd5,
    ST_RUNNING   = 3'd6
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SHIFT,
    S_ADD_INS,
    S_SEARCH,
    S_DEL_SHIFT,
    S_SKIP_RD,
    S_SKIP_WT,
    S_FETCH,
    S_RESP
  } state_t;

endpackage

// ===== design/round_robin_member_ring.sv =====
// Round-robin member ring: command in on start/busy, one result per command on out_valid.
// Add and remove take longer than the other commands, depending on the entry count: every
// search step and every shift move goes through the one-read/one-write entry memory.
// One command at a time; out_valid pulses for one cycle and the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the ring; memory contents stay undefined.
module round_robin_member_ring
  import rrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_func,
  input  logic [15:0]          in_member_id,
  input  logic signed [15:0]   in_member_score,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [15:0]          out_current_id,
  output logic signed [15:0]   out_current_score,
  output logic [15:0]          out_skipped_id,
  output logic [4:0]           out_entry_count
);

  // Entry memory, rotation order, {id, score}. One write and one registered read per cycle.
  logic [DW-1:0] mem [MAX_MEMBERS];
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [PW-1:0] mem_raddr;
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] cur_r, cur_nxt;

  // Per-command working registers
  logic [15:0]   id_r, id_nxt;
  logic [15:0]   score_r, score_nxt;
  stat_t         status_r, status_nxt;
  logic [15:0]   skipped_r, skipped_nxt;
  logic [PW-1:0] rp_r, rp_nxt;          // next address to read
  logic [CW-1:0] k_r, k_nxt;            // search reads issued
  logic          rd_act_r, rd_act_nxt;  // reads still to issue
  logic          pend_r, pend_nxt;      // a read returns data this cycle
  logic [PW-1:0] pend_addr_r, pend_addr_nxt;
  logic          pend_last_r, pend_last_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  stat_t         out_status_r, out_status_nxt;
  logic [15:0]   out_id_r, out_id_nxt;
  logic [15:0]   out_score_r, out_score_nxt;
  logic [15:0]   out_skip_r, out_skip_nxt;
  logic [CW-1:0] out_cnt_r, out_cnt_nxt;

  // Step one position forward in rotation order, wrapping at the entry count.
  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [CW-1:0] q;
    q = CW'(p) + CW'(1);
    return (q >= n) ? '0 : PW'(q);
  endfunction

  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] pend_inc;
  assign cnt_dec  = count_r - CW'(1);
  assign pend_inc = CW'(pend_addr_r) + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    id_nxt        = id_r;
    score_nxt     = score_r;
    status_nxt    = status_r;
    skipped_nxt   = skipped_r;
    rp_nxt        = rp_r;
    k_nxt         = k_r;
    rd_act_nxt    = rd_act_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_score_nxt  = out_score_r;
    out_skip_nxt   = out_skip_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = {id_r, score_r};
    mem_raddr = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          id_nxt      = in_member_id;
          score_nxt   = in_member_score;
          status_nxt  = ST_OK;
          skipped_nxt = '0;
          pend_nxt    = 1'b0;
          state_nxt   = S_FETCH;
          unique case (func_t'(in_func))
            FN_ADD: begin
              if (count_r >= CW'(MAX_MEMBERS)) begin
                status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                state_nxt = S_ADD_INS;
              end else begin
                // shift entries from the top down to the current one
                rp_nxt     = PW'(cnt_dec);
                rd_act_nxt = 1'b1;
                state_nxt  = S_ADD_SHIFT;
              end
            end
            FN_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                rp_nxt     = cur_r;
                k_nxt      = '0;
                rd_act_nxt = 1'b1;
                state_nxt  = S_SEARCH;
              end
            end
            FN_NEXT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                cur_nxt = wrap_inc(cur_r, count_r);
              end
            end
            FN_SKIP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SKIP_RD;
              end
            end
            FN_CHECK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (count_r == CW'(1)) begin
                status_nxt = ST_WINNER;
              end else begin
                status_nxt = ST_RUNNING;
              end
            end
            default: ;
          endcase
        end
      end

      // Read j, write it back at j + 1 in the next cycle; addresses never collide.
      S_ADD_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r + PW'(1);
          mem_wdata = rdata_r;
        end
        if (rd_act_r) begin
          mem_raddr     = rp_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rp_r;
          if (rp_r == cur_r) begin
            rd_act_nxt = 1'b0;
          end else begin
            rp_nxt = rp_r - PW'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_ADD_INS;
        end
      end

      S_ADD_INS: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = {id_r, score_r};
        if (count_r != '0) begin
          cur_nxt = cur_r + PW'(1);
        end
        count_nxt = count_r + CW'(1);
        state_nxt = S_FETCH;
      end

      // Pipelined search: one read issued and one compare per cycle.
      S_SEARCH: begin
        if (rd_act_r) begin
          mem_raddr     = rp_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rp_r;
          pend_last_nxt = (k_r == cnt_dec);
          k_nxt         = k_r + CW'(1);
          rp_nxt        = wrap_inc(rp_r, count_r);
          if (k_r == cnt_dec) begin
            rd_act_nxt = 1'b0;
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (rdata_r[31:16] == id_r) begin
            // hit: close the gap by moving later entries down one
            rp_nxt        = PW'(pend_inc);
            rd_act_nxt    = (pend_inc < count_r);
            pend_nxt      = 1'b0;
            k_nxt         = CW'(pend_addr_r);  // hit position kept here
            state_nxt     = S_DEL_SHIFT;
          end else if (pend_last_r) begin
            status_nxt = ST_NOT_FOUND;
            pend_nxt   = 1'b0;
            state_nxt  = S_FETCH;
          end
        end
      end

      // Read i + 1, write it at i in the next cycle.
      S_DEL_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r - PW'(1);
          mem_wdata = rdata_r;
        end
        if (rd_act_r) begin
          mem_raddr     = rp_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rp_r;
          if (CW'(rp_r) == cnt_dec) begin
            rd_act_nxt = 1'b0;
          end else begin
            rp_nxt = rp_r + PW'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = cnt_dec;
          state_nxt = S_FETCH;
          if (cnt_dec == '0) begin
            cur_nxt    = '0;
            status_nxt = ST_EMPTIED;
          end else if (k_r < CW'(cur_r)) begin
            cur_nxt = cur_r - PW'(1);
          end else if ((k_r == CW'(cur_r)) && (k_r >= cnt_dec)) begin
            cur_nxt = '0;
          end
        end
      end

      S_SKIP_RD: begin
        mem_raddr = wrap_inc(cur_r, count_r);
        state_nxt = S_SKIP_WT;
      end

      S_SKIP_WT: begin
        skipped_nxt = rdata_r[31:16];
        cur_nxt     = wrap_inc(wrap_inc(cur_r, count_r), count_r);
        state_nxt   = S_FETCH;
      end

      S_FETCH: begin
        mem_raddr = cur_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_id_nxt     = (count_r != '0) ? rdata_r[31:16] : '0;
        out_score_nxt  = (count_r != '0) ? rdata_r[15:0] : '0;
        out_skip_nxt   = skipped_r;
        out_cnt_nxt    = count_r;
        state_nxt      = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      rd_act_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      rd_act_r    <= rd_act_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    score_r      <= score_nxt;
    status_r     <= status_nxt;
    skipped_r    <= skipped_nxt;
    rp_r         <= rp_nxt;
    k_r          <= k_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_last_r  <= pend_last_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_score_r  <= out_score_nxt;
    out_skip_r   <= out_skip_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_current_id    = out_id_r;
  assign out_current_score = $signed(out_score_r);
  assign out_skipped_id    = out_skip_r;
  assign out_entry_count   = 5'(out_cnt_r);

  // Checks

  // a result only follows the response state
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_RESP))
    else $error("result strobe without response state");

  // ring never holds more than its capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_MEMBERS))
    else $error("entry count above capacity");

  // current pointer stays inside the ring, or at zero when empty
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) ? (cur_r == '0) : (CW'(cur_r) < count_r))
    else $error("current pointer out of range");

  // an accepted command makes the block busy until its result
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

endmodule

// ===== tb/sv/round_robin_member_ring_tb.sv =====
`timescale 1ns / 1ps

module round_robin_member_ring_tb;
  import rrm_pkg::*;

  // Run length and limits
  localparam int RANDOM_ITEMS   = 1650;
  localparam int PHASE_ITEMS    = RANDOM_ITEMS / 3;
  localparam int CYCLE_LIMIT    = 600000;  // worst-case remove plus long idle gaps, with margin
  localparam int SETTLE_CYCLES  = 48;      // longer than the slowest remove
  localparam int FUNC_CODE_MAX  = 7;       // 3-bit func field; codes above FN_CHECK are unused
  localparam int ID_POOL_MAX    = 7;       // small id pool, so duplicates show up often

  // One expected result transfer
  typedef struct {
    stat_t              status;
    logic [15:0]        cur_id;
    logic signed [15:0] cur_score;
    logic [15:0]        skipped_id;
    logic [4:0]         entry_count;
  } ring_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_func;
  logic [15:0]        in_member_id;
  logic signed [15:0] in_member_score;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [15:0]        out_current_id;
  logic signed [15:0] out_current_score;
  logic [15:0]        out_skipped_id;
  logic [4:0]         out_entry_count;

  round_robin_member_ring dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_member_id      (in_member_id),
    .in_member_score   (in_member_score),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_current_id    (out_current_id),
    .out_current_score (out_current_score),
    .out_skipped_id    (out_skipped_id),
    .out_entry_count   (out_entry_count)
  );

  // Shadow copy of the ring, kept in rotation order like the block's memory.
  logic [15:0]        ring_id    [MAX_MEMBERS];
  logic signed [15:0] ring_score [MAX_MEMBERS];
  int                 ring_len;
  int                 ring_cur;

  ring_result_t expected_q[$];   // results still owed by the block, oldest first
  int           mismatch_count;
  int           sent_count;      // accepted command transfers
  int           sender_idle_pct; // chance of an idle cycle before each command
  int           cycle_count;

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop, in case the block hangs or drops results.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Ring behavior: apply one command to the shadow ring and return the result it owes.
  function automatic ring_result_t apply_ring_cmd(logic [2:0] func, logic [15:0] id,
                                                  logic signed [15:0] score);
    ring_result_t r;
    stat_t        st;
    logic [15:0]  passed_over;
    int           hit;
    int           p;
    st          = ST_OK;
    passed_over = '0;
    hit         = -1;
    case (func)
      FN_ADD: begin
        if (ring_len >= MAX_MEMBERS) begin
          st = ST_FULL;
        end else if (ring_len == 0) begin
          ring_id[0]    = id;
          ring_score[0] = score;
          ring_cur      = 0;
          ring_len      = 1;
        end else begin
          // new entry goes just behind the current one: last in the rotation
          for (int i = ring_len; i > ring_cur; i--) begin
            ring_id[i]    = ring_id[i-1];
            ring_score[i] = ring_score[i-1];
          end
          ring_id[ring_cur]    = id;
          ring_score[ring_cur] = score;
          ring_cur++;
          ring_len++;
        end
      end
      FN_REMOVE: begin
        if (ring_len == 0) begin
          st = ST_EMPTY;
        end else begin
          // first match in rotation order, starting at the current entry
          for (int k = 0; k < ring_len; k++) begin
            p = (ring_cur + k) % ring_len;
            if (hit < 0 && ring_id[p] == id) hit = p;
          end
          if (hit < 0) begin
            st = ST_NOT_FOUND;
          end else begin
            for (int i = hit; i + 1 < ring_len; i++) begin
              ring_id[i]    = ring_id[i+1];
              ring_score[i] = ring_score[i+1];
            end
            ring_len--;
            if (ring_len == 0) begin
              ring_cur = 0;
              st       = ST_EMPTIED;
            end else if (hit < ring_cur) begin
              ring_cur--;
            end else if (hit == ring_cur && hit >= ring_len) begin
              ring_cur = 0;  // removed current was last slot: successor wraps to front
            end
          end
        end
      end
      FN_NEXT: begin
        if (ring_len == 0) st = ST_EMPTY;
        else ring_cur = (ring_cur + 1) % ring_len;
      end
      FN_SKIP: begin
        if (ring_len == 0) begin
          st = ST_EMPTY;
        end else begin
          passed_over = ring_id[(ring_cur + 1) % ring_len];
          ring_cur    = (ring_cur + 2) % ring_len;
        end
      end
      FN_CHECK: begin
        if (ring_len == 0) st = ST_EMPTY;
        else if (ring_len == 1) st = ST_WINNER;
        else st = ST_RUNNING;
      end
      default: ;  // unused codes: no change, plain ok
    endcase
    r.status      = st;
    r.cur_id      = (ring_len > 0) ? ring_id[ring_cur] : '0;
    r.cur_score   = (ring_len > 0) ? ring_score[ring_cur] : '0;
    r.skipped_id  = passed_over;
    r.entry_count = 5'(ring_len);
    return r;
  endfunction

  // Send one command. start stays high after the transfer; the next call either
  // presents a new command at the following falling edge or lowers start first.
  task automatic send_cmd(logic [2:0] func, logic [15:0] id, logic signed [15:0] score);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_func         <= func;
    in_member_id    <= id;
    in_member_score <= score;
    do @(posedge clk); while (busy);
    // transfer happened at this edge
    expected_q.push_back(apply_ring_cmd(func, id, score));
    sent_count++;
  endtask

  // Lower start and hold off until every owed result has come back.
  task automatic wait_ring_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] random_member_id();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, ID_POOL_MAX));
    return 16'($urandom);
  endfunction

  // Id of some entry now in the ring, so removes mostly hit.
  function automatic logic [15:0] live_member_id();
    if (ring_len == 0) return random_member_id();
    return ring_id[$urandom_range(0, ring_len - 1)];
  endfunction

  // Result checker: every out_valid strobe is one transfer, matched to the oldest
  // expectation.
  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'(out_status), '0);
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_current_id !== want.cur_id)
          report_mismatch("current id", 32'(out_current_id), 32'(want.cur_id));
        if (out_current_score !== want.cur_score)
          report_mismatch("current score", 32'(out_current_score), 32'(want.cur_score));
        if (out_skipped_id !== want.skipped_id)
          report_mismatch("skipped id", 32'(out_skipped_id), 32'(want.skipped_id));
        if (out_entry_count !== want.entry_count)
          report_mismatch("entry count", 32'(out_entry_count), 32'(want.entry_count));
      end
    end
  end

  // Every operation but add, plus an unused code, against the empty ring after reset.
  task automatic test_empty_ring();
    send_cmd(FN_REMOVE, 16'hFFFF, '0);
    send_cmd(FN_NEXT, '0, '0);
    send_cmd(FN_SKIP, '0, '0);
    send_cmd(FN_CHECK, '0, '0);
    send_cmd(3'(FUNC_CODE_MAX), 16'hFFFF, 16'sh7FFF);
  endtask

  // One entry: winner, a skip that passes over itself, next back onto itself.
  task automatic test_single_entry();
    send_cmd(FN_ADD, 16'h0000, 16'sh8000);
    send_cmd(FN_CHECK, '0, '0);
    send_cmd(FN_SKIP, '0, '0);
    send_cmd(FN_NEXT, '0, '0);
  endtask

  // Small ring with a duplicate id: rotation, misses, duplicate and current removal,
  // then removes until the ring is emptied.
  task automatic test_rotation_and_remove();
    send_cmd(FN_ADD, 16'hFFFF, 16'sh7FFF);
    send_cmd(FN_ADD, 16'h0000, 16'sh0001);   // duplicate of the id left by the single-entry test
    send_cmd(FN_ADD, 16'h5AA5, -16'sd1);
    send_cmd(FN_NEXT, '0, '0);
    send_cmd(FN_SKIP, '0, '0);
    send_cmd(FN_CHECK, '0, '0);
    send_cmd(3'(int'(FN_CHECK) + 1), 16'h1234, 16'sh4321);
    send_cmd(FN_REMOVE, 16'hBEEF, '0);        // no such id
    send_cmd(FN_REMOVE, 16'h0000, '0);        // first of the duplicates from current on
    while (ring_len > 0) send_cmd(FN_REMOVE, ring_id[ring_cur], '0);
  endtask

  // Random traffic in episodes: fill to capacity and past it, drain to empty, or a
  // mixed run of all operations.
  task automatic test_random_traffic(int idle_pct, int items);
    int     goal;
    int     pick;
    int     mix_left;
    logic [2:0] func;
    sender_idle_pct = idle_pct;
    goal = sent_count + items;
    while (sent_count < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        while (ring_len < MAX_MEMBERS) send_cmd(FN_ADD, random_member_id(), 16'($urandom));
        repeat ($urandom_range(1, 2)) send_cmd(FN_ADD, random_member_id(), 16'($urandom));
      end else if (pick < 4) begin
        while (ring_len > 0) begin
          case ($urandom_range(0, 5))
            0:       send_cmd(FN_NEXT, 16'($urandom), 16'($urandom));
            1:       send_cmd(FN_SKIP, 16'($urandom), 16'($urandom));
            2:       send_cmd(FN_CHECK, 16'($urandom), 16'($urandom));
            default: send_cmd(FN_REMOVE, live_member_id(), 16'($urandom));
          endcase
        end
        send_cmd(3'($urandom_range(int'(FN_REMOVE), int'(FN_CHECK))), live_member_id(), '0);
      end else begin
        mix_left = 10;
        while (mix_left > 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 30)      func = FN_ADD;
          else if (pick < 55) func = FN_REMOVE;
          else if (pick < 70) func = FN_NEXT;
          else if (pick < 85) func = FN_SKIP;
          else if (pick < 95) func = FN_CHECK;
          else                func = 3'($urandom_range(int'(FN_CHECK) + 1, FUNC_CODE_MAX));
          if (func == FN_REMOVE && $urandom_range(0, 4) != 0)
            send_cmd(func, live_member_id(), 16'($urandom));
          else
            send_cmd(func, random_member_id(), 16'($urandom));
          mix_left--;
        end
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = '0;
    in_member_id    = '0;
    in_member_score = '0;
    mismatch_count  = 0;
    sent_count      = 0;
    sender_idle_pct = 0;
    ring_len        = 0;
    ring_cur        = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    test_single_entry();
    test_rotation_and_remove();

    // three random phases: sender busy-ish, sender mostly idle, back to back;
    // the sender waits for the ring to go quiet between phases
    test_random_traffic(32, PHASE_ITEMS);
    wait_ring_quiet();
    test_random_traffic(84, PHASE_ITEMS);
    wait_ring_quiet();
    test_random_traffic(0, RANDOM_ITEMS - 2 * PHASE_ITEMS);

    wait_ring_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
